// ===== rtl/sorted_list_table_defines.svh =====
// Assertion macros shared by the sorted list table RTL.
`ifndef SORTED_LIST_TABLE_DEFINES_SVH
`define SORTED_LIST_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define SLT_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SLT_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define SLT_ASSERT(name, prop, msg)
`define SLT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/slt_pkg.sv =====
// Types, codes and sizes shared by the sorted list table modules.
package slt_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_REMOVE_SCAN,
      S_REMOVE_SHIFT,
      S_SEARCH,
      S_LIST,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_CLEAR,
      PTR_COUNT,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   typedef struct packed {
      op_type                    opcode;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  element;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      ptr_op_type  ptr_op;
      logic        rd_down;
      logic        wr_en;
      logic        wr_value;
      logic        wr_addr_dec;
      logic        count_inc;
      logic        count_dec;
      logic        value_load;
      logic        status_load;
      status_type  status_code;
      logic        out_load_final;
      logic        out_load_elem;
   } cmd_type;

   typedef struct packed {
      logic  out_free;
      logic  ptr_ge_count;
      logic  ptr_zero;
      logic  match;
      logic  value_below;
      logic  is_last;
      logic  count_zero;
      logic  count_full;
   } flags_type;

endpackage

// ===== rtl/slt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module slt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/slt_ctrl.sv =====
// Controller state machine that sequences insert, remove, search and list.
`include "sorted_list_table_defines.svh"

module slt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  slt_pkg::op_type     req_opcode,
   input  slt_pkg::flags_type  flags,
   output slt_pkg::cmd_type    cmd,
   output logic                req_stall
);

   slt_pkg::state_type state_ff;
   slt_pkg::state_type state_in;
   logic               accept;

   assign req_stall = (state_ff != slt_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slt_pkg::S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  slt_pkg::OP_INSERT: begin
                     state_in = flags.count_full ? slt_pkg::S_FINISH : slt_pkg::S_INSERT;
                  end
                  slt_pkg::OP_REMOVE: state_in = slt_pkg::S_REMOVE_SCAN;
                  slt_pkg::OP_SEARCH: state_in = slt_pkg::S_SEARCH;
                  slt_pkg::OP_LIST: begin
                     state_in = flags.count_zero ? slt_pkg::S_FINISH : slt_pkg::S_LIST;
                  end
                  default: state_in = slt_pkg::S_IDLE;
               endcase
            end
         end
         slt_pkg::S_INSERT: begin
            if (flags.ptr_zero || !flags.value_below) begin
               state_in = slt_pkg::S_FINISH;
            end
         end
         slt_pkg::S_REMOVE_SCAN: begin
            if (flags.ptr_ge_count) begin
               state_in = slt_pkg::S_FINISH;
            end else if (flags.match) begin
               state_in = slt_pkg::S_REMOVE_SHIFT;
            end
         end
         slt_pkg::S_REMOVE_SHIFT: begin
            if (flags.ptr_ge_count) begin
               state_in = slt_pkg::S_FINISH;
            end
         end
         slt_pkg::S_SEARCH: begin
            if (flags.ptr_ge_count || flags.match) begin
               state_in = slt_pkg::S_FINISH;
            end
         end
         slt_pkg::S_LIST: begin
            if (flags.out_free && flags.is_last) begin
               state_in = slt_pkg::S_IDLE;
            end
         end
         slt_pkg::S_FINISH: begin
            if (flags.out_free) begin
               state_in = slt_pkg::S_IDLE;
            end
         end
         default: state_in = slt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.ptr_op      = slt_pkg::PTR_HOLD;
      cmd.status_code = slt_pkg::ST_OK;
      case (state_ff)
         slt_pkg::S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  slt_pkg::OP_INSERT: begin
                     if (flags.count_full) begin
                        cmd.status_load = 1'b1;
                        cmd.status_code = slt_pkg::ST_FULL;
                     end else begin
                        cmd.ptr_op     = slt_pkg::PTR_COUNT;
                        cmd.rd_down    = 1'b1;
                        cmd.value_load = 1'b1;
                     end
                  end
                  slt_pkg::OP_REMOVE, slt_pkg::OP_SEARCH: begin
                     cmd.ptr_op     = slt_pkg::PTR_CLEAR;
                     cmd.value_load = 1'b1;
                  end
                  slt_pkg::OP_LIST: begin
                     if (flags.count_zero) begin
                        cmd.status_load = 1'b1;
                        cmd.status_code = slt_pkg::ST_EMPTY;
                     end else begin
                        cmd.ptr_op = slt_pkg::PTR_CLEAR;
                     end
                  end
                  default: cmd.ptr_op = slt_pkg::PTR_HOLD;
               endcase
            end
         end
         slt_pkg::S_INSERT: begin
            cmd.rd_down = 1'b1;
            cmd.wr_en   = 1'b1;
            if (flags.ptr_zero || !flags.value_below) begin
               cmd.wr_value    = 1'b1;
               cmd.count_inc   = 1'b1;
               cmd.status_load = 1'b1;
               cmd.status_code = slt_pkg::ST_OK;
            end else begin
               cmd.ptr_op = slt_pkg::PTR_DEC;
            end
         end
         slt_pkg::S_REMOVE_SCAN: begin
            if (flags.ptr_ge_count) begin
               cmd.status_load = 1'b1;
               cmd.status_code = slt_pkg::ST_NOT_FOUND;
            end else begin
               cmd.ptr_op = slt_pkg::PTR_INC;
            end
         end
         slt_pkg::S_REMOVE_SHIFT: begin
            if (flags.ptr_ge_count) begin
               cmd.count_dec   = 1'b1;
               cmd.status_load = 1'b1;
               cmd.status_code = slt_pkg::ST_OK;
            end else begin
               cmd.wr_en       = 1'b1;
               cmd.wr_addr_dec = 1'b1;
               cmd.ptr_op      = slt_pkg::PTR_INC;
            end
         end
         slt_pkg::S_SEARCH: begin
            if (flags.ptr_ge_count) begin
               cmd.status_load = 1'b1;
               cmd.status_code = slt_pkg::ST_NOT_FOUND;
            end else if (flags.match) begin
               cmd.status_load = 1'b1;
               cmd.status_code = slt_pkg::ST_OK;
            end else begin
               cmd.ptr_op = slt_pkg::PTR_INC;
            end
         end
         slt_pkg::S_LIST: begin
            if (flags.out_free) begin
               cmd.out_load_elem = 1'b1;
               cmd.ptr_op        = slt_pkg::PTR_INC;
            end
         end
         slt_pkg::S_FINISH: begin
            cmd.out_load_final = flags.out_free;
         end
         default: cmd.ptr_op = slt_pkg::PTR_HOLD;
      endcase
   end

   `SLT_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == slt_pkg::S_IDLE), "not idle after reset")
   `SLT_ASSERT(a_accept_leaves_idle, accept |=> (state_ff != slt_pkg::S_IDLE), "accept left idle")
   `SLT_ASSERT(a_single_write_source, !(cmd.wr_en && cmd.out_load_elem), "write during list")

endmodule

// ===== rtl/slt_dp.sv =====
// Datapath with the entry memory, walk pointer, entry count and result register.
`include "sorted_list_table_defines.svh"

module slt_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  slt_pkg::cmd_type                   cmd,
   input  logic signed [slt_pkg::DATA_W-1:0]  req_value,
   input  logic                               rsp_stall,
   output slt_pkg::flags_type                 flags,
   output logic                               rsp_valid,
   output slt_pkg::rsp_type                   rsp_payload
);

   logic [slt_pkg::COUNT_W-1:0]        ptr_ff;
   logic [slt_pkg::COUNT_W-1:0]        ptr_in;
   logic [slt_pkg::COUNT_W-1:0]        count_ff;
   logic [slt_pkg::COUNT_W-1:0]        count_in;
   logic signed [slt_pkg::DATA_W-1:0]  value_ff;
   slt_pkg::status_type                status_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   slt_pkg::rsp_type                   rsp_ff;
   slt_pkg::rsp_type                   rsp_in;
   logic [slt_pkg::COUNT_W-1:0]        rd_ptr;
   logic [slt_pkg::COUNT_W-1:0]        wr_ptr;
   logic [slt_pkg::DATA_W-1:0]         wr_data;
   logic [slt_pkg::DATA_W-1:0]         rd_data;
   logic [slt_pkg::COUNT_W:0]          ptr_next_ext;

   always_comb begin
      case (cmd.ptr_op)
         slt_pkg::PTR_HOLD:  ptr_in = ptr_ff;
         slt_pkg::PTR_CLEAR: ptr_in = '0;
         slt_pkg::PTR_COUNT: ptr_in = count_ff;
         slt_pkg::PTR_INC:   ptr_in = ptr_ff + 1'b1;
         slt_pkg::PTR_DEC:   ptr_in = ptr_ff - 1'b1;
         default:            ptr_in = ptr_ff;
      endcase
   end

   assign rd_ptr  = cmd.rd_down ? (ptr_in - 1'b1) : ptr_in;
   assign wr_ptr  = cmd.wr_addr_dec ? (ptr_ff - 1'b1) : ptr_ff;
   assign wr_data = cmd.wr_value ? value_ff : rd_data;

   slt_ram #(
      .WIDTH (slt_pkg::DATA_W),
      .DEPTH (slt_pkg::DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_ptr[slt_pkg::ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_ptr[slt_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign ptr_next_ext = {1'b0, ptr_ff} + 1'b1;

   assign flags.out_free     = !rsp_valid_ff || !rsp_stall;
   assign flags.ptr_ge_count = (ptr_ff >= count_ff);
   assign flags.ptr_zero     = (ptr_ff == '0);
   assign flags.match        = (rd_data == value_ff);
   assign flags.value_below  = (value_ff < $signed(rd_data));
   assign flags.is_last      = (ptr_next_ext == {1'b0, count_ff});
   assign flags.count_zero   = (count_ff == '0);
   assign flags.count_full   = (count_ff == slt_pkg::COUNT_W'(slt_pkg::DEPTH));

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load_final) begin
         rsp_in.status  = status_ff;
         rsp_in.element = '0;
         rsp_in.last    = 1'b1;
         rsp_valid_in   = 1'b1;
      end else if (cmd.out_load_elem) begin
         rsp_in.status  = slt_pkg::ST_OK;
         rsp_in.element = rd_data;
         rsp_in.last    = flags.is_last;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
      if (cmd.value_load) begin
         value_ff <= req_value;
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status_code;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `SLT_ASSERT(a_count_bound, count_ff <= slt_pkg::COUNT_W'(slt_pkg::DEPTH), "entry count exceeds depth")
   `SLT_ASSERT(a_write_in_range, cmd.wr_en |-> (wr_ptr <= count_ff), "write beyond stored entries")
   `SLT_ASSERT(a_load_when_free, (cmd.out_load_final || cmd.out_load_elem) |-> flags.out_free, "result register overwritten")

endmodule

// ===== rtl/sorted_list_table.sv =====
// Sorted list table: a bounded ascending multiset of signed 32-bit values.
// Each request is one transfer of opcode and value; insert, remove and search
// return one result, list returns one result per stored value (or one empty
// result) with last set on the final one. The entries sit in a one-read,
// one-write memory and are walked one entry per cycle (a list walk only
// while the result side does not stall): insert walks down from the top and
// moves each entry above the new value up, remove and search walk up from
// the bottom, and the table holds up to 16 values. List delivers one result
// per cycle when the result side does not stall. A new request is taken
// once the previous result has been loaded into the output register.
module sorted_list_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slt_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slt_pkg::rsp_type  rsp_payload
);

   slt_pkg::cmd_type    cmd;
   slt_pkg::flags_type  flags;

   slt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .flags      (flags),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   slt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_value   (req_payload.value),
      .rsp_stall   (rsp_stall),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
